// File: rtl/c6502x_pkg.sv
// Package for the 6502 execute unit: operation codes, transaction structs
// and the decoded micro-operation passed from the front to the back end.
// No dependencies.
package c6502x_pkg;

    localparam logic [6:0] OP_LDA = 7'd0;
    localparam logic [6:0] OP_LDX = 7'd1;
    localparam logic [6:0] OP_LDY = 7'd2;
    localparam logic [6:0] OP_STA = 7'd3;
    localparam logic [6:0] OP_STX = 7'd4;
    localparam logic [6:0] OP_STY = 7'd5;
    localparam logic [6:0] OP_TAX = 7'd6;
    localparam logic [6:0] OP_TAY = 7'd7;
    localparam logic [6:0] OP_TSX = 7'd8;
    localparam logic [6:0] OP_TXA = 7'd9;
    localparam logic [6:0] OP_TXS = 7'd10;
    localparam logic [6:0] OP_TYA = 7'd11;
    localparam logic [6:0] OP_PHA = 7'd12;
    localparam logic [6:0] OP_PHP = 7'd13;
    localparam logic [6:0] OP_PLA = 7'd14;
    localparam logic [6:0] OP_PLP = 7'd15;
    localparam logic [6:0] OP_DEC = 7'd16;
    localparam logic [6:0] OP_DEX = 7'd17;
    localparam logic [6:0] OP_DEY = 7'd18;
    localparam logic [6:0] OP_INC = 7'd19;
    localparam logic [6:0] OP_INX = 7'd20;
    localparam logic [6:0] OP_INY = 7'd21;
    localparam logic [6:0] OP_ADC = 7'd22;
    localparam logic [6:0] OP_SBC = 7'd23;
    localparam logic [6:0] OP_AND = 7'd24;
    localparam logic [6:0] OP_EOR = 7'd25;
    localparam logic [6:0] OP_ORA = 7'd26;
    localparam logic [6:0] OP_ASLM = 7'd27;
    localparam logic [6:0] OP_ASLA = 7'd28;
    localparam logic [6:0] OP_LSRM = 7'd29;
    localparam logic [6:0] OP_LSRA = 7'd30;
    localparam logic [6:0] OP_ROLM = 7'd31;
    localparam logic [6:0] OP_ROLA = 7'd32;
    localparam logic [6:0] OP_RORM = 7'd33;
    localparam logic [6:0] OP_RORA = 7'd34;
    localparam logic [6:0] OP_CLC = 7'd35;
    localparam logic [6:0] OP_CLD = 7'd36;
    localparam logic [6:0] OP_CLI = 7'd37;
    localparam logic [6:0] OP_CLV = 7'd38;
    localparam logic [6:0] OP_SEC = 7'd39;
    localparam logic [6:0] OP_SED = 7'd40;
    localparam logic [6:0] OP_SEI = 7'd41;
    localparam logic [6:0] OP_CMP = 7'd42;
    localparam logic [6:0] OP_CPX = 7'd43;
    localparam logic [6:0] OP_CPY = 7'd44;
    localparam logic [6:0] OP_BIT = 7'd45;
    localparam logic [6:0] OP_BCC = 7'd46;
    localparam logic [6:0] OP_BCS = 7'd47;
    localparam logic [6:0] OP_BEQ = 7'd48;
    localparam logic [6:0] OP_BMI = 7'd49;
    localparam logic [6:0] OP_BNE = 7'd50;
    localparam logic [6:0] OP_BPL = 7'd51;
    localparam logic [6:0] OP_BVC = 7'd52;
    localparam logic [6:0] OP_BVS = 7'd53;
    localparam logic [6:0] OP_JMP = 7'd54;
    localparam logic [6:0] OP_NOP = 7'd55;
    localparam logic [6:0] OP_ALR = 7'd56;
    localparam logic [6:0] OP_ANC = 7'd57;
    localparam logic [6:0] OP_DCP = 7'd58;
    localparam logic [6:0] OP_ISB = 7'd59;
    localparam logic [6:0] OP_LAX = 7'd60;
    localparam logic [6:0] OP_RLA = 7'd61;
    localparam logic [6:0] OP_RRA = 7'd62;
    localparam logic [6:0] OP_SAX = 7'd63;
    localparam logic [6:0] OP_SLO = 7'd64;
    localparam logic [6:0] OP_SRE = 7'd65;

    localparam logic [15:0] STACK_PAGE = 16'h0100;
    localparam logic [15:0] PAGE_MASK = 16'hFF00;
    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] P_RESET = 8'h24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [6:0] op;
        logic [7:0] operand;
        logic [15:0] eff_addr;
        logic [15:0] next_pc;
    } in_item_t;

    typedef struct packed {
        logic [15:0] new_pc;
        logic mem_write;
        logic [15:0] write_addr;
        logic [7:0] write_data;
        logic [1:0] extra_cycles;
        logic [7:0] acc_out;
        logic [7:0] x_out;
        logic [7:0] y_out;
        logic [7:0] sp_out;
        logic [7:0] status_out;
    } out_item_t;

    // Decoded operation: precomputed operand-only values plus the raw code.
    typedef struct packed {
        logic [6:0] op;
        logic [7:0] m;
        logic [7:0] m_dec;
        logic [7:0] m_inc;
        logic [15:0] eff_addr;
        logic [15:0] next_pc;
        logic page_cross;
    } uop_t;

endpackage

// File: rtl/c6502x_front.sv
// Front end of the 6502 execute unit: accepts transactions, precomputes
// operand-only values and queues the decoded operation. Uses c6502x_pkg.
module c6502x_front
    import c6502x_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_item_t in_item,
    output logic uop_valid,
    input  logic uop_ready,
    output uop_t uop
);

    uop_t q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0] count_reg, count_next;
    logic push, pop;
    uop_t dec;

    always_comb
    begin
        dec.op = in_item.op;
        dec.m = in_item.operand;
        dec.m_dec = in_item.operand - 8'd1;
        dec.m_inc = in_item.operand + 8'd1;
        dec.eff_addr = in_item.eff_addr;
        dec.next_pc = in_item.next_pc;
        dec.page_cross = (in_item.next_pc & PAGE_MASK) != (in_item.eff_addr & PAGE_MASK);
    end

    assign in_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign uop_valid = count_reg != '0;
    assign uop = q_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = uop_valid && uop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");
    a_empty_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !uop_valid)
        else $error("valid with empty queue");

endmodule

// File: rtl/c6502x_back.sv
// Back end of the 6502 execute unit: holds A, X, Y, S, P, executes one
// queued operation per cycle while the output is not stalled into an output register. Uses c6502x_pkg.
module c6502x_back
    import c6502x_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic uop_valid,
    output logic uop_ready,
    input  uop_t uop,
    output logic out_valid,
    input  logic out_ready,
    output out_item_t out_item
);

    logic [7:0] a_reg, a_next, x_reg, x_next, y_reg, y_next, s_reg, s_next, p_reg, p_next;
    logic out_valid_reg;
    out_item_t out_reg, res;
    logic fire;
    logic [7:0] m, r, sh, addv;
    logic [8:0] sum;
    logic take, wr, nz_en, c_en, c_val, v_en, v_val;
    logic [7:0] nz_val;
    logic [15:0] waddr, pc;
    logic [7:0] wdata;
    logic [7:0] cmp_src;
    logic use_add, use_cmp;
    logic cin;

    assign uop_ready = !out_valid_reg || out_ready;
    assign fire = uop_valid && uop_ready;
    assign out_valid = out_valid_reg;
    assign out_item = out_reg;
    assign m = uop.m;

    always_comb
    begin
        a_next = a_reg;
        x_next = x_reg;
        y_next = y_reg;
        s_next = s_reg;
        p_next = p_reg;
        wr = 1'b0;
        waddr = uop.eff_addr;
        wdata = 8'd0;
        pc = uop.next_pc;
        take = 1'b0;
        nz_en = 1'b0;
        nz_val = 8'd0;
        c_en = 1'b0;
        c_val = 1'b0;
        v_en = 1'b0;
        v_val = 1'b0;
        use_add = 1'b0;
        use_cmp = 1'b0;
        addv = 8'd0;
        cmp_src = a_reg;
        r = 8'd0;
        sh = 8'd0;
        cin = 1'b1;

        case (uop.op)
            OP_ASLM, OP_ASLA, OP_SLO:
            begin
                r = (uop.op == OP_ASLA) ? a_reg : m;
                sh = {r[6:0], 1'b0};
                c_en = 1'b1;
                c_val = r[7];
            end
            OP_ROLM, OP_ROLA, OP_RLA:
            begin
                r = (uop.op == OP_ROLA) ? a_reg : m;
                sh = {r[6:0], p_reg[0]};
                c_en = 1'b1;
                c_val = r[7];
            end
            OP_LSRM, OP_LSRA, OP_SRE, OP_ALR:
            begin
                r = (uop.op == OP_LSRA) ? a_reg : ((uop.op == OP_ALR) ? (a_reg & m) : m);
                sh = {1'b0, r[7:1]};
                c_en = 1'b1;
                c_val = r[0];
            end
            OP_RORM, OP_RORA, OP_RRA:
            begin
                r = (uop.op == OP_RORA) ? a_reg : m;
                sh = {p_reg[0], r[7:1]};
                c_en = 1'b1;
                c_val = r[0];
            end
            default:
            begin
                r = 8'd0;
            end
        endcase

        case (uop.op)
            OP_ADC: begin use_add = 1'b1; addv = m; end
            OP_SBC: begin use_add = 1'b1; addv = ~m; end
            OP_ISB: begin use_add = 1'b1; addv = ~uop.m_inc; end
            OP_RRA: begin use_add = 1'b1; addv = sh; end
            OP_CMP: begin use_cmp = 1'b1; addv = ~m; end
            OP_CPX: begin use_cmp = 1'b1; addv = ~m; cmp_src = x_reg; end
            OP_CPY: begin use_cmp = 1'b1; addv = ~m; cmp_src = y_reg; end
            OP_DCP: begin use_cmp = 1'b1; addv = ~uop.m_dec; end
            default: addv = 8'd0;
        endcase
        if (!use_add)
        begin
            use_add = 1'b0;
        end
        // RRA adds with the carry that its rotate has just produced.
        if (use_add)
        begin
            cin = (uop.op == OP_RRA) ? m[0] : p_reg[0];
        end
        sum = {1'b0, (use_add ? a_reg : cmp_src)} + {1'b0, addv} + {8'd0, cin};

        case (uop.op)
            OP_LDA: begin a_next = m; nz_en = 1'b1; nz_val = m; end
            OP_LDX: begin x_next = m; nz_en = 1'b1; nz_val = m; end
            OP_LDY: begin y_next = m; nz_en = 1'b1; nz_val = m; end
            OP_STA: begin wr = 1'b1; wdata = a_reg; end
            OP_STX: begin wr = 1'b1; wdata = x_reg; end
            OP_STY: begin wr = 1'b1; wdata = y_reg; end
            OP_TAX: begin x_next = a_reg; nz_en = 1'b1; nz_val = a_reg; end
            OP_TAY: begin y_next = a_reg; nz_en = 1'b1; nz_val = a_reg; end
            OP_TSX: begin x_next = s_reg; nz_en = 1'b1; nz_val = s_reg; end
            OP_TXA: begin a_next = x_reg; nz_en = 1'b1; nz_val = x_reg; end
            OP_TXS: s_next = x_reg;
            OP_TYA: begin a_next = y_reg; nz_en = 1'b1; nz_val = y_reg; end
            OP_PHA, OP_PHP:
            begin
                wr = 1'b1;
                waddr = STACK_PAGE | {8'd0, s_reg};
                wdata = (uop.op == OP_PHA) ? a_reg : (p_reg | 8'h30);
                s_next = s_reg - 8'd1;
            end
            OP_PLA: begin s_next = s_reg + 8'd1; a_next = m; nz_en = 1'b1; nz_val = m; end
            OP_PLP: s_next = s_reg + 8'd1;
            OP_DEC: begin wr = 1'b1; wdata = uop.m_dec; nz_en = 1'b1; nz_val = uop.m_dec; end
            OP_INC: begin wr = 1'b1; wdata = uop.m_inc; nz_en = 1'b1; nz_val = uop.m_inc; end
            OP_DEX: begin x_next = x_reg - 8'd1; nz_en = 1'b1; nz_val = x_next; end
            OP_DEY: begin y_next = y_reg - 8'd1; nz_en = 1'b1; nz_val = y_next; end
            OP_INX: begin x_next = x_reg + 8'd1; nz_en = 1'b1; nz_val = x_next; end
            OP_INY: begin y_next = y_reg + 8'd1; nz_en = 1'b1; nz_val = y_next; end
            OP_ADC, OP_SBC, OP_ISB, OP_RRA:
            begin
                a_next = sum[7:0];
                nz_en = 1'b1;
                nz_val = sum[7:0];
                c_en = 1'b1;
                c_val = sum[8];
                v_en = 1'b1;
                v_val = ~(a_reg[7] ^ addv[7]) & (a_reg[7] ^ sum[7]);
                if (uop.op == OP_ISB)
                begin
                    wr = 1'b1;
                    wdata = uop.m_inc;
                end
                if (uop.op == OP_RRA)
                begin
                    wr = 1'b1;
                    wdata = sh;
                end
            end
            OP_AND: begin a_next = a_reg & m; nz_en = 1'b1; nz_val = a_next; end
            OP_EOR: begin a_next = a_reg ^ m; nz_en = 1'b1; nz_val = a_next; end
            OP_ORA: begin a_next = a_reg | m; nz_en = 1'b1; nz_val = a_next; end
            OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM:
            begin
                wr = 1'b1;
                wdata = sh;
                nz_en = 1'b1;
                nz_val = sh;
            end
            OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA, OP_ALR:
            begin
                a_next = sh;
                nz_en = 1'b1;
                nz_val = sh;
            end
            OP_CLC: begin c_en = 1'b1; c_val = 1'b0; end
            OP_SEC: begin c_en = 1'b1; c_val = 1'b1; end
            OP_CLV: begin v_en = 1'b1; v_val = 1'b0; end
            OP_CMP, OP_CPX, OP_CPY, OP_DCP:
            begin
                nz_en = 1'b1;
                nz_val = sum[7:0];
                c_en = 1'b1;
                c_val = sum[8];
                if (uop.op == OP_DCP)
                begin
                    wr = 1'b1;
                    wdata = uop.m_dec;
                end
            end
            OP_BCC: take = !p_reg[0];
            OP_BCS: take = p_reg[0];
            OP_BEQ: take = p_reg[1];
            OP_BMI: take = p_reg[7];
            OP_BNE: take = !p_reg[1];
            OP_BPL: take = !p_reg[7];
            OP_BVC: take = !p_reg[6];
            OP_BVS: take = p_reg[6];
            OP_JMP: pc = uop.eff_addr;
            OP_ANC:
            begin
                a_next = a_reg & m;
                nz_en = 1'b1;
                nz_val = a_next;
                c_en = 1'b1;
                c_val = a_next[7];
            end
            OP_LAX: begin a_next = m; x_next = m; nz_en = 1'b1; nz_val = m; end
            OP_RLA: begin wr = 1'b1; wdata = sh; a_next = a_reg & sh; nz_en = 1'b1; nz_val = a_next; end
            OP_SLO: begin wr = 1'b1; wdata = sh; a_next = a_reg | sh; nz_en = 1'b1; nz_val = a_next; end
            OP_SRE: begin wr = 1'b1; wdata = sh; a_next = a_reg ^ sh; nz_en = 1'b1; nz_val = a_next; end
            OP_SAX: begin wr = 1'b1; wdata = a_reg & x_reg; end
            default: pc = uop.next_pc;
        endcase

        if (nz_en)
        begin
            p_next[7] = nz_val[7];
            p_next[1] = nz_val == 8'd0;
        end
        if (c_en)
        begin
            p_next[0] = c_val;
        end
        if (v_en)
        begin
            p_next[6] = v_val;
        end
        case (uop.op)
            OP_CLD: p_next[3] = 1'b0;
            OP_SED: p_next[3] = 1'b1;
            OP_CLI: p_next[2] = 1'b0;
            OP_SEI: p_next[2] = 1'b1;
            OP_BIT:
            begin
                p_next[1] = (a_reg & m) == 8'd0;
                p_next[7] = m[7];
                p_next[6] = m[6];
            end
            OP_PLP: p_next = (m & 8'hEF) | 8'h20;
            default: p_next[3] = p_next[3];
        endcase

        if (take)
        begin
            pc = uop.eff_addr;
        end
        if (!wr)
        begin
            waddr = 16'd0;
        end

        res.new_pc = pc;
        res.mem_write = wr;
        res.write_addr = waddr;
        res.write_data = wdata;
        res.extra_cycles = take ? (uop.page_cross ? 2'd2 : 2'd1) : 2'd0;
        res.acc_out = a_next;
        res.x_out = x_next;
        res.y_out = y_next;
        res.sp_out = s_next;
        res.status_out = p_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= 8'd0;
            x_reg <= 8'd0;
            y_reg <= 8'd0;
            s_reg <= SP_RESET;
            p_reg <= P_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                a_reg <= a_next;
                x_reg <= x_next;
                y_reg <= y_next;
                s_reg <= s_next;
                p_reg <= p_next;
            end
            if (uop_ready)
            begin
                out_valid_reg <= uop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    a_regs_match_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_reg.acc_out == a_reg && out_reg.sp_out == s_reg
                  && out_reg.status_out == p_reg))
        else $error("output register disagrees with register file");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(a_reg) && $stable(p_reg))
        else $error("register file changed during stall");
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.mem_write) |-> out_item.write_addr == 16'd0
            && out_item.write_data == 8'd0)
        else $error("write fields not zero without write");
    a_extra_branch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.extra_cycles != 2'd0) |-> !out_item.mem_write)
        else $error("branch with memory write");

endmodule

// File: rtl/cpu6502_instruction_execute.sv
// Path: an input transaction is registered in the front queue, then in the
// output register. Throughput: one transaction per cycle while out_ready
// holds, set by the execute step in the back end.
// Reset: A, X, Y clear to 0, S to 0xFD, P to 0x24; queue and output empty.
// Depends on c6502x_pkg, c6502x_front and c6502x_back.
module cpu6502_instruction_execute
    import c6502x_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_item_t in_item,
    output logic out_valid,
    input  logic out_ready,
    output out_item_t out_item
);

    logic uop_valid, uop_ready;
    uop_t uop;

    c6502x_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .uop_valid(uop_valid),
        .uop_ready(uop_ready),
        .uop(uop)
    );

    c6502x_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .uop_valid(uop_valid),
        .uop_ready(uop_ready),
        .uop(uop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item)
    );

endmodule
